### rtl/umcp_pkg.sv
// ----------------------------------------------------------------------------
// umcp_pkg
// Types and constants shared by the memory command parser modules.
// ----------------------------------------------------------------------------
package umcp_pkg;

    // Protocol characters.
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_W_UP    = 8'h57;
    localparam logic [7:0] CH_W_LO    = 8'h77;
    localparam logic [7:0] CH_R_UP    = 8'h52;
    localparam logic [7:0] CH_R_LO    = 8'h72;
    localparam logic [7:0] CH_B_UP    = 8'h42;
    localparam logic [7:0] CH_B_LO    = 8'h62;
    localparam logic [7:0] CH_S_UP    = 8'h53;
    localparam logic [7:0] CH_S_LO    = 8'h73;

    // Result kinds.
    localparam logic [1:0] KIND_ERROR = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    typedef enum logic [2:0] {
        PH_OP      = 3'd0,
        PH_TYPE    = 3'd1,
        PH_ADDR_HI = 3'd2,
        PH_ADDR_LO = 3'd3,
        PH_VALUE   = 3'd4
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic        is_read;
        logic        is_string;
        logic [15:0] address;
    } parse_state_t;

    typedef struct packed {
        logic [1:0]  cmd_kind;
        logic [15:0] mem_address;
        logic [7:0]  write_data;
    } result_t;

endpackage

### rtl/umcp_decoder.sv
// ----------------------------------------------------------------------------
// umcp_decoder
// Combinational parse step: next parser state and the optional result for
// one received byte.
// ----------------------------------------------------------------------------
module umcp_decoder (
    input  umcp_pkg::parse_state_t state,
    input  logic [7:0]             rx_byte,
    output umcp_pkg::parse_state_t state_next,
    output logic                   result_valid,
    output umcp_pkg::result_t      result
);

    logic is_newline;
    logic op_write;
    logic op_read;
    logic type_byte;
    logic type_string;

    assign is_newline  = (rx_byte == umcp_pkg::CH_NEWLINE);
    assign op_write    = (rx_byte == umcp_pkg::CH_W_UP) || (rx_byte == umcp_pkg::CH_W_LO);
    assign op_read     = (rx_byte == umcp_pkg::CH_R_UP) || (rx_byte == umcp_pkg::CH_R_LO);
    assign type_byte   = (rx_byte == umcp_pkg::CH_B_UP) || (rx_byte == umcp_pkg::CH_B_LO);
    assign type_string = (rx_byte == umcp_pkg::CH_S_UP) || (rx_byte == umcp_pkg::CH_S_LO);

    // Next state.
    always_comb begin
        state_next = state;
        if (is_newline) begin
            state_next.phase = umcp_pkg::PH_OP;
        end else begin
            case (state.phase)
                umcp_pkg::PH_TYPE: begin
                    if (type_byte || type_string) begin
                        state_next.is_string = type_string;
                        state_next.phase     = umcp_pkg::PH_ADDR_HI;
                    end else begin
                        state_next.phase = umcp_pkg::PH_OP;
                    end
                end
                umcp_pkg::PH_ADDR_HI: begin
                    state_next.address = {rx_byte, 8'h00};
                    state_next.phase   = umcp_pkg::PH_ADDR_LO;
                end
                umcp_pkg::PH_ADDR_LO: begin
                    state_next.address = {state.address[15:8], rx_byte};
                    state_next.phase   = umcp_pkg::PH_VALUE;
                end
                umcp_pkg::PH_VALUE: begin
                    // String mode walks the address, wrapping at 16 bits.
                    if (state.is_string) begin
                        state_next.address = state.address + 16'd1;
                    end
                end
                default: begin
                    // Unused phase codes behave as waiting for the operation letter.
                    if (op_write || op_read) begin
                        state_next.is_read = op_read;
                        state_next.phase   = umcp_pkg::PH_TYPE;
                    end else begin
                        state_next.phase = umcp_pkg::PH_OP;
                    end
                end
            endcase
        end
    end

    // Result.
    always_comb begin
        result_valid       = 1'b0;
        result.cmd_kind    = umcp_pkg::KIND_ERROR;
        result.mem_address = 16'h0000;
        result.write_data  = 8'h00;
        if (!is_newline) begin
            case (state.phase)
                umcp_pkg::PH_TYPE: begin
                    result_valid = !(type_byte || type_string);
                end
                umcp_pkg::PH_ADDR_HI,
                umcp_pkg::PH_ADDR_LO: begin
                    result_valid = 1'b0;
                end
                umcp_pkg::PH_VALUE: begin
                    result_valid       = 1'b1;
                    result.mem_address = state.address;
                    if (state.is_read) begin
                        result.cmd_kind = umcp_pkg::KIND_READ;
                    end else begin
                        result.cmd_kind   = umcp_pkg::KIND_WRITE;
                        result.write_data = rx_byte;
                    end
                end
                default: begin
                    result_valid = !(op_write || op_read);
                end
            endcase
        end
    end

endmodule

### rtl/umcp_out_buf.sv
// ----------------------------------------------------------------------------
// umcp_out_buf
// Output register with a skid stage, so one more result can be taken while
// the receiver stalls.
// ----------------------------------------------------------------------------
module umcp_out_buf (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  umcp_pkg::result_t in_result,
    output logic              in_ready,
    output logic              out_valid,
    output umcp_pkg::result_t out_result,
    input  logic              out_ready
);

    logic              out_valid_reg;
    logic              out_valid_next;
    umcp_pkg::result_t out_data_reg;
    umcp_pkg::result_t out_data_next;
    logic              skid_valid_reg;
    logic              skid_valid_next;
    umcp_pkg::result_t skid_data_reg;
    umcp_pkg::result_t skid_data_next;
    logic              out_free;

    assign in_ready   = !skid_valid_reg;
    assign out_valid  = out_valid_reg;
    assign out_result = out_data_reg;
    assign out_free   = !out_valid_reg || out_ready;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_free) begin
            if (skid_valid_reg) begin
                // No new request enters while the skid stage is full.
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = in_valid;
                if (in_valid) begin
                    out_data_next = in_result;
                end
            end
        end else if (in_valid) begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

### rtl/uart_memory_command_parser.sv
// ----------------------------------------------------------------------------
// uart_memory_command_parser
// Turns received serial bytes into memory write and read requests.
// ----------------------------------------------------------------------------
// Bytes from the serial receiver enter on the s_ stream, one per request.
// A command is an operation letter (W/w or R/r), a type letter (B/b or
// S/s), a high and a low address byte, then any number of value bytes.
// Every value byte yields one request on the m_ stream: a write carries the
// byte, a read carries zero data. String mode steps the address after each
// request. A newline returns to waiting for the operation letter, and a bad
// letter yields an error result with zero address and data.
// The parse step is one level of logic between the parser state register
// and the output register: a byte is taken every cycle while s_tready is
// high, and its result is registered. A skid stage behind the output
// register takes one more result while the receiver stalls; s_tready
// drops only while that stage is full.
// Reset clears the parser to waiting for the operation letter, write, byte
// mode and address zero, and empties the output stages.
// ----------------------------------------------------------------------------
module uart_memory_command_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [15:0] mem_address, [23:16] write_data
    output logic [1:0]  m_tuser    // [1:0] cmd_kind
);

    umcp_pkg::parse_state_t state_reg;
    umcp_pkg::parse_state_t state_next;
    logic                   s_accept;
    logic                   dec_valid;
    umcp_pkg::result_t      dec_result;
    umcp_pkg::result_t      m_result;

    assign s_accept = s_tvalid && s_tready;

    umcp_decoder u_decoder (
        .state        (state_reg),
        .rx_byte      (s_tdata),
        .state_next   (state_next),
        .result_valid (dec_valid),
        .result       (dec_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase     <= umcp_pkg::PH_OP;
            state_reg.is_read   <= 1'b0;
            state_reg.is_string <= 1'b0;
            state_reg.address   <= 16'h0000;
        end else if (s_accept) begin
            state_reg <= state_next;
        end
    end

    umcp_out_buf u_out_buf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_accept && dec_valid),
        .in_result  (dec_result),
        .in_ready   (s_tready),
        .out_valid  (m_tvalid),
        .out_result (m_result),
        .out_ready  (m_tready)
    );

    assign m_tdata = {m_result.write_data, m_result.mem_address};
    assign m_tuser = m_result.cmd_kind;

endmodule
